### sv/ura_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ura_pkg;

  localparam int MAX_SHOTS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int DIST_W    = 10;
  localparam int SHOT_W    = 4;
  localparam int ALARM_W   = 2;
  localparam int CFG_DW    = 16;
  localparam int CFG_AW    = 3;
  localparam int SCALE_MUL = 17;
  localparam int SCALE_DIV = 1000;
  // 15 valid shots times the scale divisor fit in 14 bits, then shifted by the quotient width
  localparam int DEN_W     = 14 + DIST_W;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIG = 3'd1;
  localparam logic [2:0] PH_RISE = 3'd2;
  localparam logic [2:0] PH_HIGH = 3'd3;
  localparam logic [2:0] PH_GAP  = 3'd4;

  localparam logic [CFG_AW-1:0] REG_TRIGGER = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TIMEOUT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAP     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SHOTS   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_NEAR    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_MID     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FAR     = 3'd6;

  localparam logic [7:0]        RST_TRIGGER = 8'd15;
  localparam logic [15:0]       RST_TIMEOUT = 16'd50000;
  localparam logic [15:0]       RST_GAP     = 16'd10000;
  localparam logic [SHOT_W-1:0] RST_SHOTS   = 4'd5;
  localparam logic [DIST_W-1:0] RST_NEAR    = 10'd8;
  localparam logic [DIST_W-1:0] RST_MID     = 10'd15;
  localparam logic [DIST_W-1:0] RST_FAR     = 10'd25;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_START,
    OP_BUMP,
    OP_TICK_ONE,
    OP_CLR_TICK,
    OP_PH_RISE,
    OP_PH_HIGH,
    OP_PH_GAP,
    OP_PH_TRIG,
    OP_PH_IDLE,
    OP_ACCUM,
    OP_NEXT,
    OP_DIV_INIT,
    OP_DEN_SHR,
    OP_DIV_STEP,
    OP_SAT,
    OP_ZERO_D,
    OP_STORE
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_START,
    C_ECHO,
    C_CNT_TRIG,
    C_CNT_TO,
    C_CNT_GAP,
    C_GAP_ZERO,
    C_SHOTS_DONE,
    C_VALID_ZERO,
    C_OVF,
    C_BIT_ZERO
  } cond_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctl_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       start;
    logic       echo;
    logic       cnt_trig;
    logic       cnt_to;
    logic       cnt_gap;
    logic       gap_zero;
    logic       shots_done;
    logic       valid_zero;
    logic       ovf;
    logic       bit_zero;
  } flags_t;

  typedef struct packed {
    logic [7:0]        trigger_ticks;
    logic [15:0]       echo_timeout;
    logic [15:0]       gap_ticks;
    logic [SHOT_W-1:0] shot_count;
    logic [DIST_W-1:0] near_limit;
    logic [DIST_W-1:0] mid_limit;
    logic [DIST_W-1:0] far_limit;
  } cfg_t;

endpackage

`default_nettype wire

### sv/ultrasonic_range_averager.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    start_req_i, echo_i (one microsecond tick)
// out      out  out_valid_o / out_ready_i  trigger_o, busy_res_o, done_res_o,
//                                          distance_cm_o, good_shots_o, alarm_level_o
// cfg      in   cfg_we_i                   cfg_index_i, cfg_data_i
//
// Each tick is accepted, runs a microcode program, then waits in the result
// register until out_ready_i takes it. The last tick of a measurement is
// the long one: a 10-step restoring divide runs as a microcode loop.
// Reset clears the sequencer and measurement state and loads register defaults.
// No tick is accepted while a result waits on out_ready_i.

module ultrasonic_range_averager #(
  parameter int MAX_SHOTS  = ura_pkg::MAX_SHOTS_DEF,
  parameter int COUNT_BITS = ura_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          start_req_i,
  input  wire logic                          echo_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               trigger_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [ura_pkg::DIST_W-1:0]         distance_cm_o,
  output logic [ura_pkg::SHOT_W-1:0]         good_shots_o,
  output logic [ura_pkg::ALARM_W-1:0]        alarm_level_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ura_pkg::CFG_AW-1:0]    cfg_index_i,
  input  wire logic [ura_pkg::CFG_DW-1:0]    cfg_data_i
);

  ura_pkg::cfg_t   cfg;
  ura_pkg::ctl_t   ctl;
  ura_pkg::flags_t flags;

  ura_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ura_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_i     (flags),
    .ctl_o       (ctl)
  );

  ura_dp #(
    .MAX_SHOTS  (MAX_SHOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .start_i      (start_req_i),
    .echo_i       (echo_i),
    .cfg_i        (cfg),
    .flags_o      (flags),
    .trigger_o    (trigger_o),
    .busy_o       (busy_res_o),
    .done_o       (done_res_o),
    .distance_o   (distance_cm_o),
    .good_shots_o (good_shots_o),
    .alarm_o      (alarm_level_o)
  );

endmodule

`default_nettype wire

### sv/ura_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ura_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ura_pkg::CFG_AW-1:0] cfg_index_i,
  input  wire logic [ura_pkg::CFG_DW-1:0] cfg_data_i,
  output ura_pkg::cfg_t                  cfg_o
);

  ura_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= ura_pkg::RST_TRIGGER;
      cfg_q.echo_timeout  <= ura_pkg::RST_TIMEOUT;
      cfg_q.gap_ticks     <= ura_pkg::RST_GAP;
      cfg_q.shot_count    <= ura_pkg::RST_SHOTS;
      cfg_q.near_limit    <= ura_pkg::RST_NEAR;
      cfg_q.mid_limit     <= ura_pkg::RST_MID;
      cfg_q.far_limit     <= ura_pkg::RST_FAR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ura_pkg::REG_TRIGGER: cfg_q.trigger_ticks <= cfg_data_i[7:0];
        ura_pkg::REG_TIMEOUT: cfg_q.echo_timeout  <= cfg_data_i[15:0];
        ura_pkg::REG_GAP:     cfg_q.gap_ticks     <= cfg_data_i[15:0];
        ura_pkg::REG_SHOTS:   cfg_q.shot_count    <= cfg_data_i[ura_pkg::SHOT_W-1:0];
        ura_pkg::REG_NEAR:    cfg_q.near_limit    <= cfg_data_i[ura_pkg::DIST_W-1:0];
        ura_pkg::REG_MID:     cfg_q.mid_limit     <= cfg_data_i[ura_pkg::DIST_W-1:0];
        ura_pkg::REG_FAR:     cfg_q.far_limit     <= cfg_data_i[ura_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/ura_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module ura_useq (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire ura_pkg::flags_t flags_i,
  output ura_pkg::ctl_t   ctl_o
);

  localparam int UPC_W = 5;

  typedef struct packed {
    ura_pkg::op_e   op;
    ura_pkg::cond_e cond;
    logic           inv;
    logic [UPC_W-1:0] tgt;
    logic           fin;
  } ucw_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [UPC_W-1:0] A_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] A_TRIG  = 5'd2;
  localparam logic [UPC_W-1:0] A_RISE  = 5'd5;
  localparam logic [UPC_W-1:0] A_RLOW  = 5'd9;
  localparam logic [UPC_W-1:0] A_END   = 5'd11;
  localparam logic [UPC_W-1:0] A_HIGH  = 5'd12;
  localparam logic [UPC_W-1:0] A_ACC   = 5'd16;
  localparam logic [UPC_W-1:0] A_FIN   = 5'd17;
  localparam logic [UPC_W-1:0] A_GAP   = 5'd19;
  localparam logic [UPC_W-1:0] A_NEXT  = 5'd21;
  localparam logic [UPC_W-1:0] A_RES   = 5'd24;
  localparam logic [UPC_W-1:0] A_LOOP  = 5'd27;
  localparam logic [UPC_W-1:0] A_STORE = 5'd28;
  localparam logic [UPC_W-1:0] A_SAT   = 5'd29;
  localparam logic [UPC_W-1:0] A_ZERO  = 5'd30;
  localparam logic [UPC_W-1:0] A_BAD   = 5'd31;

  function automatic ucw_t w_step(input ura_pkg::op_e op);
    ucw_t w;
    w.op   = op;
    w.cond = ura_pkg::C_ALWAYS;
    w.inv  = 1'b1;
    w.tgt  = '0;
    w.fin  = 1'b0;
    return w;
  endfunction

  function automatic ucw_t w_jmp(input ura_pkg::op_e op, input ura_pkg::cond_e c,
                                 input logic inv, input logic [UPC_W-1:0] tgt);
    ucw_t w;
    w.op   = op;
    w.cond = c;
    w.inv  = inv;
    w.tgt  = tgt;
    w.fin  = 1'b0;
    return w;
  endfunction

  function automatic ucw_t w_fin(input ura_pkg::op_e op);
    ucw_t w;
    w.op   = op;
    w.cond = ura_pkg::C_ALWAYS;
    w.inv  = 1'b0;
    w.tgt  = '0;
    w.fin  = 1'b1;
    return w;
  endfunction

  function automatic ucw_t rom_word(input logic [UPC_W-1:0] a);
    ucw_t w;
    unique case (a)
      A_IDLE:         w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_START, 1'b1, A_END);
      A_IDLE + 5'd1:  w = w_fin(ura_pkg::OP_START);
      A_TRIG:         w = w_step(ura_pkg::OP_BUMP);
      A_TRIG + 5'd1:  w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_CNT_TRIG, 1'b1, A_END);
      A_TRIG + 5'd2:  w = w_fin(ura_pkg::OP_PH_RISE);
      A_RISE:         w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_ECHO, 1'b1, A_RLOW);
      A_RISE + 5'd1:  w = w_step(ura_pkg::OP_TICK_ONE);
      A_RISE + 5'd2:  w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_CNT_TO, 1'b0, A_FIN);
      A_RISE + 5'd3:  w = w_fin(ura_pkg::OP_PH_HIGH);
      A_RLOW:         w = w_step(ura_pkg::OP_BUMP);
      A_RLOW + 5'd1:  w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_CNT_TO, 1'b0, A_FIN);
      A_END:          w = w_fin(ura_pkg::OP_NOP);
      A_HIGH:         w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_ECHO, 1'b1, A_ACC);
      A_HIGH + 5'd1:  w = w_step(ura_pkg::OP_BUMP);
      A_HIGH + 5'd2:  w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_CNT_TO, 1'b0, A_FIN);
      A_HIGH + 5'd3:  w = w_fin(ura_pkg::OP_NOP);
      A_ACC:          w = w_step(ura_pkg::OP_ACCUM);
      // end of shot: clear the count, skip the gap when it is zero
      A_FIN:          w = w_jmp(ura_pkg::OP_CLR_TICK, ura_pkg::C_GAP_ZERO, 1'b0, A_NEXT);
      A_FIN + 5'd1:   w = w_fin(ura_pkg::OP_PH_GAP);
      A_GAP:          w = w_step(ura_pkg::OP_BUMP);
      A_GAP + 5'd1:   w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_CNT_GAP, 1'b1, A_END);
      A_NEXT:         w = w_step(ura_pkg::OP_NEXT);
      A_NEXT + 5'd1:  w = w_jmp(ura_pkg::OP_NOP, ura_pkg::C_SHOTS_DONE, 1'b0, A_RES);
      A_NEXT + 5'd2:  w = w_fin(ura_pkg::OP_PH_TRIG);
      A_RES:          w = w_jmp(ura_pkg::OP_PH_IDLE, ura_pkg::C_VALID_ZERO, 1'b0, A_ZERO);
      A_RES + 5'd1:   w = w_step(ura_pkg::OP_DIV_INIT);
      A_RES + 5'd2:   w = w_jmp(ura_pkg::OP_DEN_SHR, ura_pkg::C_OVF, 1'b0, A_SAT);
      // one quotient bit per step, MSB first
      A_LOOP:         w = w_jmp(ura_pkg::OP_DIV_STEP, ura_pkg::C_BIT_ZERO, 1'b1, A_LOOP);
      A_STORE:        w = w_fin(ura_pkg::OP_STORE);
      A_SAT:          w = w_jmp(ura_pkg::OP_SAT, ura_pkg::C_ALWAYS, 1'b0, A_STORE);
      A_ZERO:         w = w_jmp(ura_pkg::OP_ZERO_D, ura_pkg::C_ALWAYS, 1'b0, A_STORE);
      default:        w = w_fin(ura_pkg::OP_PH_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry_of(input logic [2:0] ph);
    logic [UPC_W-1:0] a;
    unique case (ph)
      ura_pkg::PH_IDLE: a = A_IDLE;
      ura_pkg::PH_TRIG: a = A_TRIG;
      ura_pkg::PH_RISE: a = A_RISE;
      ura_pkg::PH_HIGH: a = A_HIGH;
      ura_pkg::PH_GAP:  a = A_GAP;
      default:          a = A_BAD;
    endcase
    return a;
  endfunction

  logic [1:0]       state_q, state_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  ucw_t             word;
  logic             cond_hit;
  logic             take;

  assign word = rom_word(upc_q);

  always_comb begin
    unique case (word.cond)
      ura_pkg::C_ALWAYS:     cond_hit = 1'b1;
      ura_pkg::C_START:      cond_hit = flags_i.start;
      ura_pkg::C_ECHO:       cond_hit = flags_i.echo;
      ura_pkg::C_CNT_TRIG:   cond_hit = flags_i.cnt_trig;
      ura_pkg::C_CNT_TO:     cond_hit = flags_i.cnt_to;
      ura_pkg::C_CNT_GAP:    cond_hit = flags_i.cnt_gap;
      ura_pkg::C_GAP_ZERO:   cond_hit = flags_i.gap_zero;
      ura_pkg::C_SHOTS_DONE: cond_hit = flags_i.shots_done;
      ura_pkg::C_VALID_ZERO: cond_hit = flags_i.valid_zero;
      ura_pkg::C_OVF:        cond_hit = flags_i.ovf;
      ura_pkg::C_BIT_ZERO:   cond_hit = flags_i.bit_zero;
      default:               cond_hit = 1'b0;
    endcase
  end

  assign take = cond_hit ^ word.inv;

  always_comb begin
    state_d    = state_q;
    upc_d      = upc_q;
    ctl_o.load = 1'b0;
    ctl_o.op   = ura_pkg::OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_RUN;
          upc_d      = entry_of(flags_i.phase);
        end
      end
      S_RUN: begin
        ctl_o.op = word.op;
        if (word.fin) begin
          state_d = S_OUT;
        end else if (take) begin
          upc_d = word.tgt;
        end else begin
          upc_d = upc_q + 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upc_q   <= A_IDLE;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is held");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RUN))
    else $error("accepted request did not start the program");

  a_fin_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && word.fin) |=> out_valid_o)
    else $error("finished program did not present a result");

endmodule

`default_nettype wire

### sv/ura_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ura_dp #(
  parameter int MAX_SHOTS  = ura_pkg::MAX_SHOTS_DEF,
  parameter int COUNT_BITS = ura_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ura_pkg::ctl_t                 ctl_i,
  input  wire logic                          start_i,
  input  wire logic                          echo_i,
  input  wire ura_pkg::cfg_t                 cfg_i,
  output ura_pkg::flags_t                    flags_o,
  output logic                               trigger_o,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [ura_pkg::DIST_W-1:0]         distance_o,
  output logic [ura_pkg::SHOT_W-1:0]         good_shots_o,
  output logic [ura_pkg::ALARM_W-1:0]        alarm_o
);

  localparam int CNT_W  = COUNT_BITS;
  localparam int LIM_W  = (COUNT_BITS > ura_pkg::CFG_DW) ? COUNT_BITS : ura_pkg::CFG_DW;
  localparam int SUM_W  = COUNT_BITS + $clog2(MAX_SHOTS);
  localparam int NUM_W  = SUM_W + $clog2(ura_pkg::SCALE_MUL + 1);
  localparam int DIV_W  = (NUM_W > ura_pkg::DEN_W) ? NUM_W : ura_pkg::DEN_W;
  localparam int BASE_W = ura_pkg::DEN_W - ura_pkg::DIST_W;
  localparam int BIT_W  = $clog2(ura_pkg::DIST_W);
  localparam int DW     = ura_pkg::DIST_W;
  localparam int SW     = ura_pkg::SHOT_W;
  localparam logic [SW:0] SHOT_MAX = (SW + 1)'(MAX_SHOTS);

  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_CLEAR = 2'd0;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_FAR   = 2'd1;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_MID   = 2'd2;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_NEAR  = 2'd3;

  logic [2:0]                     phase_q, phase_d;
  logic [CNT_W-1:0]               tick_q, tick_d;
  logic [SW-1:0]                  shot_q, shot_d;
  logic [SUM_W-1:0]               sum_q, sum_d;
  logic [SW-1:0]                  valid_q, valid_d;
  logic [DW-1:0]                  dist_q, dist_d;
  logic [ura_pkg::ALARM_W-1:0]    alarm_q, alarm_d;
  logic                           done_q, done_d;
  logic                           start_q, echo_q;
  logic [DIV_W-1:0]               rem_q, rem_d;
  logic [DIV_W-1:0]               den_q, den_d;
  logic [DW-1:0]                  quo_q, quo_d;
  logic [BIT_W-1:0]               bit_q, bit_d;

  logic [LIM_W-1:0]  tick_ext;
  logic [LIM_W-1:0]  trig_lim;
  logic [LIM_W-1:0]  to_lim;
  logic              cnt_full;
  logic [SW:0]       shots_req;
  logic [SW:0]       shots_want;
  logic [BASE_W-1:0] den_base;
  logic              rem_ge;
  logic [ura_pkg::ALARM_W-1:0] alarm_new;

  assign tick_ext = LIM_W'(tick_q);
  assign cnt_full = &tick_q;
  assign trig_lim = (cfg_i.trigger_ticks == '0) ? LIM_W'(1) : LIM_W'(cfg_i.trigger_ticks);
  assign to_lim   = (cfg_i.echo_timeout == '0) ? LIM_W'(1) : LIM_W'(cfg_i.echo_timeout);

  // clamp requested shots to 1..MAX_SHOTS
  assign shots_req  = {1'b0, cfg_i.shot_count};
  assign shots_want = (shots_req == '0) ? (SW + 1)'(1) :
                      (shots_req > SHOT_MAX) ? SHOT_MAX : shots_req;

  assign den_base = BASE_W'(valid_q) * BASE_W'(ura_pkg::SCALE_DIV);
  assign rem_ge   = (rem_q >= den_q);

  // nested thresholds: each level needs all lower ones to hold too
  always_comb begin
    if (quo_q > cfg_i.far_limit) begin
      alarm_new = ALARM_CLEAR;
    end else if (quo_q > cfg_i.mid_limit) begin
      alarm_new = ALARM_FAR;
    end else if (quo_q > cfg_i.near_limit) begin
      alarm_new = ALARM_MID;
    end else begin
      alarm_new = ALARM_NEAR;
    end
  end

  always_comb begin
    flags_o.phase      = phase_q;
    flags_o.start      = start_q;
    flags_o.echo       = echo_q;
    flags_o.cnt_trig   = (tick_ext >= trig_lim) || cnt_full;
    flags_o.cnt_to     = (tick_ext >= to_lim) || cnt_full;
    flags_o.cnt_gap    = (tick_ext >= LIM_W'(cfg_i.gap_ticks)) || cnt_full;
    flags_o.gap_zero   = (cfg_i.gap_ticks == '0);
    flags_o.shots_done = ({1'b0, shot_q} >= shots_want);
    flags_o.valid_zero = (valid_q == '0);
    flags_o.ovf        = rem_ge;
    flags_o.bit_zero   = (bit_q == '0);
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    shot_d  = shot_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    dist_d  = dist_q;
    alarm_d = alarm_q;
    done_d  = done_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    bit_d   = bit_q;
    if (ctl_i.load) done_d = 1'b0;
    unique case (ctl_i.op)
      ura_pkg::OP_NOP: ;
      ura_pkg::OP_START: begin
        phase_d = ura_pkg::PH_TRIG;
        tick_d  = '0;
        shot_d  = '0;
        sum_d   = '0;
        valid_d = '0;
      end
      ura_pkg::OP_BUMP: begin
        if (!cnt_full) tick_d = tick_q + 1'b1;
      end
      ura_pkg::OP_TICK_ONE: tick_d = CNT_W'(1);
      ura_pkg::OP_CLR_TICK: tick_d = '0;
      ura_pkg::OP_PH_RISE: begin
        phase_d = ura_pkg::PH_RISE;
        tick_d  = '0;
      end
      ura_pkg::OP_PH_HIGH: phase_d = ura_pkg::PH_HIGH;
      ura_pkg::OP_PH_GAP:  phase_d = ura_pkg::PH_GAP;
      ura_pkg::OP_PH_TRIG: phase_d = ura_pkg::PH_TRIG;
      ura_pkg::OP_PH_IDLE: phase_d = ura_pkg::PH_IDLE;
      ura_pkg::OP_ACCUM: begin
        sum_d   = sum_q + SUM_W'(tick_q);
        valid_d = valid_q + 1'b1;
      end
      ura_pkg::OP_NEXT: begin
        shot_d = shot_q + 1'b1;
        tick_d = '0;
      end
      ura_pkg::OP_DIV_INIT: begin
        rem_d = DIV_W'(sum_q) * DIV_W'(ura_pkg::SCALE_MUL);
        den_d = DIV_W'(den_base) << DW;
        bit_d = BIT_W'(DW - 1);
        quo_d = '0;
      end
      ura_pkg::OP_DEN_SHR: den_d = den_q >> 1;
      ura_pkg::OP_DIV_STEP: begin
        if (rem_ge) rem_d = rem_q - den_q;
        quo_d = {quo_q[DW-2:0], rem_ge};
        den_d = den_q >> 1;
        bit_d = bit_q - 1'b1;
      end
      ura_pkg::OP_SAT:    quo_d = '1;
      ura_pkg::OP_ZERO_D: quo_d = '0;
      ura_pkg::OP_STORE: begin
        dist_d  = quo_q;
        alarm_d = alarm_new;
        done_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ura_pkg::PH_IDLE;
      tick_q  <= '0;
      shot_q  <= '0;
      sum_q   <= '0;
      valid_q <= '0;
      dist_q  <= '0;
      alarm_q <= ALARM_CLEAR;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shot_q  <= shot_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
      dist_q  <= dist_d;
      alarm_q <= alarm_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      start_q <= start_i;
      echo_q  <= echo_i;
    end
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    bit_q <= bit_d;
  end

  assign trigger_o    = (phase_q == ura_pkg::PH_TRIG);
  assign busy_o       = (phase_q != ura_pkg::PH_IDLE);
  assign done_o       = done_q;
  assign distance_o   = dist_q;
  assign good_shots_o = valid_q;
  assign alarm_o      = alarm_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q == ura_pkg::PH_IDLE))
    else $error("done flagged while a measurement is running");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(ctl_i.op == ura_pkg::OP_STORE))
    else $error("done raised without a result store");

endmodule

`default_nettype wire

### bench/ura_range_checker.sv
`timescale 1ns / 1ps

module ura_range_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        start_req_i,
  input  logic                        echo_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        trigger_i,
  input  logic                        busy_i,
  input  logic                        done_i,
  input  logic [ura_pkg::DIST_W-1:0]  distance_i,
  input  logic [ura_pkg::SHOT_W-1:0]  good_shots_i,
  input  logic [ura_pkg::ALARM_W-1:0] alarm_i,
  input  logic                        cfg_we_i,
  input  logic [ura_pkg::CFG_AW-1:0]  cfg_index_i,
  input  logic [ura_pkg::CFG_DW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam logic [15:0] COUNT_FULL = 16'hFFFF;
  localparam int unsigned SOUND_MUL = 17;
  localparam int unsigned SOUND_DIV = 1000;
  localparam int unsigned SHOTS_MAX = ura_pkg::MAX_SHOTS_DEF;
  localparam int REPORT_LIMIT = 10;

  localparam logic [ura_pkg::DIST_W-1:0]  DIST_MAX    = '1;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_CLEAR = 2'd0;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_FAR   = 2'd1;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_MID   = 2'd2;
  localparam logic [ura_pkg::ALARM_W-1:0] ALARM_NEAR  = 2'd3;

  typedef struct packed {
    logic                        trigger;
    logic                        busy;
    logic                        done;
    logic [ura_pkg::DIST_W-1:0]  distance;
    logic [ura_pkg::SHOT_W-1:0]  good;
    logic [ura_pkg::ALARM_W-1:0] alarm;
  } reading_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_TRIG,
    SEQ_RISE,
    SEQ_HIGH,
    SEQ_GAP
  } seq_e;

  // register copy
  logic [7:0]                 trig_ticks;
  logic [15:0]                echo_limit;
  logic [15:0]                gap_len;
  logic [ura_pkg::SHOT_W-1:0] shots_cfg;
  logic [ura_pkg::DIST_W-1:0] near_lim;
  logic [ura_pkg::DIST_W-1:0] mid_lim;
  logic [ura_pkg::DIST_W-1:0] far_lim;

  // measurement state
  seq_e                        seq;
  logic [15:0]                 tick_cnt;
  logic [ura_pkg::SHOT_W-1:0]  shot_idx;
  int unsigned                 width_sum;
  logic [ura_pkg::SHOT_W-1:0]  valid_shots;
  logic [ura_pkg::DIST_W-1:0]  last_dist;
  logic [ura_pkg::ALARM_W-1:0] last_alarm;
  logic                        done_flag;

  reading_t expected_readings[$];
  int       fails = 0;

  function automatic bit count_expired(logic [15:0] limit);
    logic [15:0] lim;
    lim = (limit == '0) ? 16'd1 : limit;
    return (tick_cnt >= lim) || (tick_cnt == COUNT_FULL);
  endfunction

  function automatic void bump_count();
    if (tick_cnt != COUNT_FULL) tick_cnt = tick_cnt + 16'd1;
  endfunction

  // Advance to the next shot, or store the averaged distance after the last one.
  function automatic void advance_shot();
    int unsigned     wanted;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    shot_idx = shot_idx + 1'b1;
    tick_cnt = '0;
    wanted = shots_cfg;
    if (wanted == 0) wanted = 1;
    if (wanted > SHOTS_MAX) wanted = SHOTS_MAX;
    if (shot_idx < wanted) begin
      seq = SEQ_TRIG;
    end else begin
      last_dist = '0;
      if (valid_shots != '0) begin
        num = width_sum;
        num = num * SOUND_MUL;
        den = valid_shots;
        den = den * SOUND_DIV;
        quo = num / den;
        last_dist = (quo > DIST_MAX) ? DIST_MAX : quo[ura_pkg::DIST_W-1:0];
      end
      // nested zones: each level also needs the looser limits
      if (last_dist <= far_lim) begin
        if (last_dist <= mid_lim) last_alarm = (last_dist <= near_lim) ? ALARM_NEAR : ALARM_MID;
        else last_alarm = ALARM_FAR;
      end else begin
        last_alarm = ALARM_CLEAR;
      end
      done_flag = 1'b1;
      seq = SEQ_IDLE;
    end
  endfunction

  function automatic void end_shot();
    tick_cnt = '0;
    if (gap_len == '0) advance_shot();
    else seq = SEQ_GAP;
  endfunction

  function automatic reading_t predict_reading(logic start, logic echo);
    reading_t r;
    done_flag = 1'b0;
    case (seq)
      SEQ_IDLE: begin
        if (start) begin
          seq = SEQ_TRIG;
          tick_cnt = '0;
          shot_idx = '0;
          width_sum = 0;
          valid_shots = '0;
        end
      end
      SEQ_TRIG: begin
        bump_count();
        if (count_expired({8'd0, trig_ticks})) begin
          seq = SEQ_RISE;
          tick_cnt = '0;
        end
      end
      SEQ_RISE: begin
        if (echo) begin
          tick_cnt = 16'd1;
          if (count_expired(echo_limit)) end_shot();
          else seq = SEQ_HIGH;
        end else begin
          bump_count();
          if (count_expired(echo_limit)) end_shot();
        end
      end
      SEQ_HIGH: begin
        if (echo) begin
          bump_count();
          if (count_expired(echo_limit)) end_shot();
        end else begin
          width_sum = width_sum + tick_cnt;
          valid_shots = valid_shots + 1'b1;
          end_shot();
        end
      end
      SEQ_GAP: begin
        bump_count();
        if (tick_cnt >= gap_len || tick_cnt == COUNT_FULL) advance_shot();
      end
      default: seq = SEQ_IDLE;
    endcase
    r.trigger  = (seq == SEQ_TRIG);
    r.busy     = (seq != SEQ_IDLE);
    r.done     = done_flag;
    r.distance = last_dist;
    r.good     = valid_shots;
    r.alarm    = last_alarm;
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      trig_ticks  = ura_pkg::RST_TRIGGER;
      echo_limit  = ura_pkg::RST_TIMEOUT;
      gap_len     = ura_pkg::RST_GAP;
      shots_cfg   = ura_pkg::RST_SHOTS;
      near_lim    = ura_pkg::RST_NEAR;
      mid_lim     = ura_pkg::RST_MID;
      far_lim     = ura_pkg::RST_FAR;
      seq         = SEQ_IDLE;
      tick_cnt    = '0;
      shot_idx    = '0;
      width_sum   = 0;
      valid_shots = '0;
      last_dist   = '0;
      last_alarm  = ALARM_CLEAR;
      done_flag   = 1'b0;
      expected_readings.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{trigger_i, busy_i, done_i, distance_i, good_shots_i, alarm_i};
        if (expected_readings.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("unexpected reading: trig=%0b busy=%0b done=%0b dist=%0d good=%0d alarm=%0d",
                     got.trigger, got.busy, got.done, got.distance, got.good, got.alarm);
        end else begin
          want = expected_readings.pop_front();
          if (got.trigger !== want.trigger || got.busy !== want.busy ||
              got.done !== want.done || got.distance !== want.distance ||
              got.good !== want.good || got.alarm !== want.alarm) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("mismatch at %0t: expected trig=%0b busy=%0b done=%0b dist=%0d good=%0d alarm=%0d, got trig=%0b busy=%0b done=%0b dist=%0d good=%0d alarm=%0d",
                       $realtime, want.trigger, want.busy, want.done, want.distance,
                       want.good, want.alarm, got.trigger, got.busy, got.done,
                       got.distance, got.good, got.alarm);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_readings.push_back(predict_reading(start_req_i, echo_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          ura_pkg::REG_TRIGGER: trig_ticks = cfg_data_i[7:0];
          ura_pkg::REG_TIMEOUT: echo_limit = cfg_data_i[15:0];
          ura_pkg::REG_GAP:     gap_len    = cfg_data_i[15:0];
          ura_pkg::REG_SHOTS:   shots_cfg  = cfg_data_i[ura_pkg::SHOT_W-1:0];
          ura_pkg::REG_NEAR:    near_lim   = cfg_data_i[ura_pkg::DIST_W-1:0];
          ura_pkg::REG_MID:     mid_lim    = cfg_data_i[ura_pkg::DIST_W-1:0];
          ura_pkg::REG_FAR:     far_lim    = cfg_data_i[ura_pkg::DIST_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o    <= expected_readings.size();
    fail_count_o <= fails;
  end

endmodule

### bench/tb_ultrasonic_range_averager.sv
`timescale 1ns / 1ps

module tb_ultrasonic_range_averager;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_WAIT        = 17;
  localparam int SETTLE_CYCLES   = 30;
  localparam int PHASE_COUNT     = 6;
  localparam int LONG_PULSE      = 60;

  // no register sits at this index
  localparam logic [ura_pkg::CFG_AW-1:0] REG_UNMAPPED = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       start_req = 1'b0;
  logic                       echo = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [ura_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [ura_pkg::CFG_DW-1:0] cfg_data = '0;

  logic                        in_ready;
  logic                        out_valid;
  logic                        trigger;
  logic                        busy_res;
  logic                        done_res;
  logic [ura_pkg::DIST_W-1:0]  distance_cm;
  logic [ura_pkg::SHOT_W-1:0]  good_shots;
  logic [ura_pkg::ALARM_W-1:0] alarm_level;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit pace_on = 1'b1;
  bit hold_req = 1'b0;

  ultrasonic_range_averager u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .start_req_i   (start_req),
    .echo_i        (echo),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .trigger_o     (trigger),
    .busy_res_o    (busy_res),
    .done_res_o    (done_res),
    .distance_cm_o (distance_cm),
    .good_shots_o  (good_shots),
    .alarm_level_o (alarm_level),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ura_range_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .start_req_i  (start_req),
    .echo_i       (echo),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .trigger_i    (trigger),
    .busy_i       (busy_res),
    .done_i       (done_res),
    .distance_i   (distance_cm),
    .good_shots_i (good_shots),
    .alarm_i      (alarm_level),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Reading sink: random stalls, plus one long hold-off that backs up the input.
  initial begin : sink
    bit hold_done;
    int w;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        w = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_tick(bit s, bit e);
    int w;
    w = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= s;
    echo      <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_run(bit s, bit e, int n);
    repeat (n) send_tick(s, e);
  endtask

  task automatic write_reg(logic [ura_pkg::CFG_AW-1:0] idx, logic [ura_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering ticks and hold until every reading is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stim
    bit echo_lvl;
    int run_left;
    echo_lvl = 1'b0;
    run_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero registers: trigger, timeout and shot count all act as one
    write_reg(ura_pkg::REG_TRIGGER, 16'hFF00);
    write_reg(ura_pkg::REG_TIMEOUT, 16'h0000);
    write_reg(ura_pkg::REG_GAP, 16'h0000);
    write_reg(ura_pkg::REG_SHOTS, 16'hFFF0);
    write_reg(ura_pkg::REG_NEAR, 16'hFC00);
    write_reg(ura_pkg::REG_MID, 16'h0000);
    write_reg(ura_pkg::REG_FAR, 16'h0000);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 1);
    send_run(1'b0, 1'b1, 1);
    send_run(1'b1, 1'b1, 1);
    send_run(1'b0, 1'b1, 2);
    drain();

    // one valid shot, one shot lost to the high timeout, short gaps
    write_reg(ura_pkg::REG_TRIGGER, 16'd1);
    write_reg(ura_pkg::REG_TIMEOUT, 16'd3);
    write_reg(ura_pkg::REG_GAP, 16'd1);
    write_reg(ura_pkg::REG_SHOTS, 16'd2);
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 1);
    send_run(1'b0, 1'b1, 2);
    send_run(1'b0, 1'b0, 2);
    send_run(1'b0, 1'b1, 4);
    send_run(1'b0, 1'b0, 1);
    drain();

    // widest timeout and limits, one long echo back to back
    pace_on = 1'b0;
    write_reg(ura_pkg::REG_TRIGGER, 16'd3);
    write_reg(ura_pkg::REG_TIMEOUT, 16'hFFFF);
    write_reg(ura_pkg::REG_GAP, 16'd0);
    write_reg(ura_pkg::REG_SHOTS, 16'd1);
    write_reg(ura_pkg::REG_NEAR, 16'h03FF);
    write_reg(ura_pkg::REG_MID, 16'h03FF);
    write_reg(ura_pkg::REG_FAR, 16'h03FF);
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 5);
    send_run(1'b0, 1'b1, LONG_PULSE);
    send_run(1'b0, 1'b0, 2);
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      bit            wide;
      int            n_items;
      int            lo_max;
      int            hi_min;
      int            hi_max;
      bit            e;
      logic [15:0]   v;
      wide = p[0];
      if (p > 0) drain();
      if (wide) begin
        // long echoes against small thresholds so every alarm zone shows up
        write_reg(ura_pkg::REG_TRIGGER, 16'($urandom_range(1, 2)));
        write_reg(ura_pkg::REG_TIMEOUT, 16'($urandom_range(150, 300)));
        write_reg(ura_pkg::REG_GAP, 16'($urandom_range(0, 1)));
        write_reg(ura_pkg::REG_SHOTS, 16'($urandom_range(1, 2)));
        write_reg(ura_pkg::REG_NEAR, 16'($urandom_range(0, 2)));
        write_reg(ura_pkg::REG_MID, 16'($urandom_range(0, 3)));
        write_reg(ura_pkg::REG_FAR, 16'($urandom_range(0, 3)));
        lo_max  = 3;
        hi_min  = 40;
        hi_max  = 230;
        n_items = 80;
      end else begin
        v = 16'($urandom);
        v[7:0] = 8'($urandom_range(0, 3));
        write_reg(ura_pkg::REG_TRIGGER, v);
        write_reg(ura_pkg::REG_TIMEOUT, 16'($urandom_range(0, 10)));
        write_reg(ura_pkg::REG_GAP, 16'($urandom_range(0, 3)));
        v = 16'($urandom);
        write_reg(ura_pkg::REG_SHOTS, v);
        v = 16'($urandom);
        write_reg(ura_pkg::REG_NEAR, v);
        v = 16'($urandom);
        write_reg(ura_pkg::REG_MID, v);
        v = 16'($urandom);
        write_reg(ura_pkg::REG_FAR, v);
        lo_max  = 12;
        hi_min  = 1;
        hi_max  = 12;
        n_items = 40;
      end
      write_reg(REG_UNMAPPED, 16'($urandom));
      pace_on = (p != 2);
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (run_left == 0) begin
          echo_lvl = ~echo_lvl;
          run_left = echo_lvl ? $urandom_range(hi_min, hi_max) : $urandom_range(1, lo_max);
        end
        run_left--;
        e = echo_lvl;
        // drop in a stray echo level now and then
        if ($urandom_range(0, 9) == 0) e = 1'($urandom_range(0, 1));
        send_tick($urandom_range(0, 3) != 0, e);
      end
    end

    pace_on = 1'b1;
    drain();
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### ultrasonic_range_averager.f
sv/ura_pkg.sv
sv/ura_cfg.sv
sv/ura_useq.sv
sv/ura_dp.sv
sv/ultrasonic_range_averager.sv
bench/ura_range_checker.sv
bench/tb_ultrasonic_range_averager.sv
